### design/lsr_pkg.sv
`default_nettype none
package lsr_pkg;

	localparam int LSR_DEPTH = 32;
	localparam int DATA_W    = 32;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_DUMP = 2'd2,
		OP_REV  = 2'd3
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage
`default_nettype wire

### design/lsr_in_if.sv
`default_nettype none
interface lsr_in_if
	import lsr_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          op;
	logic signed [DATA_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);
endinterface
`default_nettype wire

### design/lsr_out_if.sv
`default_nettype none
interface lsr_out_if
	import lsr_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data_out;
	logic [STAT_W-1:0]        status;
	logic                     last;

	modport source (output valid, output data_out, output status, output last, input ready);
	modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface
`default_nettype wire

### design/lsr_ram.sv
`default_nettype none
module lsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### design/lifo_stack_with_reverse.sv
`default_nettype none
// Channel  Dir  Handshake          Payload
// req      in   valid / ready      op, push_value
// rsp      out  valid / ready      data_out, status, last
//
// Push, pop and reverse each give one result; dump gives one result per stored
// word, one RAM read per result. Each result passes through the RAM read stage and then the
// output register. The words sit in a ring in one RAM, addressed from a base
// and a direction, so reverse only moves the base and flips the direction.
// Reset clears fill count, base, direction and the sequencer; the RAM is not
// cleared. With rsp.ready low a valid output register holds, and once the RAM
// read stage also holds an item its read data holds and req.ready drops.
module lifo_stack_with_reverse
	import lsr_pkg::*;
#(
	parameter int DEPTH = LSR_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lsr_in_if.sink     req,
	lsr_out_if.source  rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     n_q, n_d;
	logic [AW-1:0]     base_q, base_d;
	logic              dir_q, dir_d;
	logic [AW-1:0]     dump_idx_q;

	logic              v_s1, mem_s1, last_s1;
	logic [STAT_W-1:0] status_s1;

	logic              ov_q, olast_q;
	logic [DATA_W-1:0] odata_q;
	logic [STAT_W-1:0] ostat_q;

	logic              adv, s1_free, acc, empty, full;
	logic              issue, rd_en, wr_en, is_mem, is_last, dump_start, dump_idx_inc;
	logic [STAT_W-1:0] stat;
	logic [CW-1:0]     nm1;
	logic [AW-1:0]     lidx, paddr;
	logic [AW:0]       fwd, bwd;
	logic [DATA_W-1:0] rd_data, wr_data;

	assign adv      = !ov_q || rsp.ready;
	assign s1_free  = !v_s1 || adv;
	assign req.ready = s1_free && (state_q == ST_IDLE);
	assign acc      = req.valid && req.ready;
	assign empty    = (n_q == '0);
	assign full     = (n_q == CW'(DEPTH));
	assign nm1      = n_q - CW'(1);
	assign wr_data  = req.push_value;

	// logical index to ring address
	always_comb begin
		fwd = {1'b0, base_q} + {1'b0, lidx};
		if (fwd >= (AW+1)'(DEPTH)) begin
			fwd = fwd - (AW+1)'(DEPTH);
		end
		if (base_q >= lidx) begin
			bwd = {1'b0, base_q} - {1'b0, lidx};
		end else begin
			bwd = {1'b0, base_q} + (AW+1)'(DEPTH) - {1'b0, lidx};
		end
		paddr = dir_q ? bwd[AW-1:0] : fwd[AW-1:0];
	end

	// issue logic
	always_comb begin
		issue        = 1'b0;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		is_mem       = 1'b0;
		is_last      = 1'b1;
		stat         = STAT_OK;
		lidx         = '0;
		n_d          = n_q;
		base_d       = base_q;
		dir_d        = dir_q;
		dump_start   = 1'b0;
		dump_idx_inc = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					issue = 1'b1;
					unique case (op_t'(req.op))
						OP_PUSH: begin
							if (full) begin
								stat = STAT_FULL;
							end else begin
								wr_en = 1'b1;
								lidx  = n_q[AW-1:0];
								n_d   = n_q + CW'(1);
							end
						end
						OP_POP: begin
							if (empty) begin
								stat = STAT_EMPTY;
							end else begin
								rd_en  = 1'b1;
								is_mem = 1'b1;
								lidx   = nm1[AW-1:0];
								n_d    = nm1;
							end
						end
						OP_DUMP: begin
							if (empty) begin
								stat = STAT_EMPTY;
							end else begin
								rd_en      = 1'b1;
								is_mem     = 1'b1;
								is_last    = (n_q == CW'(1));
								dump_start = (n_q != CW'(1));
							end
						end
						OP_REV: begin
							if (empty) begin
								stat = STAT_EMPTY;
							end else begin
								// old top becomes the bottom, walking the other way
								lidx   = nm1[AW-1:0];
								base_d = paddr;
								dir_d  = !dir_q;
							end
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (s1_free) begin
					issue        = 1'b1;
					rd_en        = 1'b1;
					is_mem       = 1'b1;
					lidx         = dump_idx_q;
					is_last      = (CW'(dump_idx_q) + CW'(1) == n_q);
					dump_idx_inc = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (dump_start) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (issue && is_last) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			base_q     <= '0;
			dir_q      <= 1'b0;
			dump_idx_q <= '0;
			v_s1       <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			base_q  <= base_d;
			dir_q   <= dir_d;
			if (dump_start) begin
				dump_idx_q <= AW'(1);
			end else if (dump_idx_inc) begin
				dump_idx_q <= dump_idx_q + AW'(1);
			end
			if (s1_free) begin
				v_s1 <= issue;
			end
			if (adv) begin
				ov_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			mem_s1    <= is_mem;
			last_s1   <= is_last;
			status_s1 <= stat;
		end
		if (adv && v_s1) begin
			odata_q <= mem_s1 ? rd_data : '0;
			ostat_q <= status_s1;
			olast_q <= last_s1;
		end
	end

	lsr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (paddr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (paddr),
		.rdata (rd_data)
	);

	assign rsp.valid    = ov_q;
	assign rsp.data_out = odata_q;
	assign rsp.status   = ostat_q;
	assign rsp.last     = olast_q;

endmodule
`default_nettype wire
